[hw/rtl/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// Minimum coin change package
// Field widths, register indexes and reset values shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    localparam int COIN_BITS  = 10;
    localparam int COUNT_BITS = 10;
    localparam int CFG_BITS   = 10;

    localparam logic CFG_SECOND_COIN = 1'b0;
    localparam logic CFG_THIRD_COIN  = 1'b1;

    localparam logic [COIN_BITS-1:0] SECOND_COIN_RESET = 10'd3;
    localparam logic [COIN_BITS-1:0] THIRD_COIN_RESET  = 10'd4;

endpackage

`default_nettype wire

[hw/rtl/mcc_table.sv]
// ----------------------------------------------------------------------------
// Minimum coin change scratch table
// Single write port, single registered read port memory of best counts.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_table #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/mcc_min.sv]
// ----------------------------------------------------------------------------
// Minimum coin change compare unit
// Keeps the smaller of a running minimum and a candidate count enabled by use_cand.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_min #(
    parameter int WIDTH = 10
) (
    input  wire logic [WIDTH-1:0] cur,
    input  wire logic [WIDTH-1:0] cand,
    input  wire logic             use_cand,
    output logic      [WIDTH-1:0] lowest
);

    always_comb
    begin
        if (use_cand && (cand < cur))
        begin
            lowest = cand;
        end
        else
        begin
            lowest = cur;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/min_coin_change.sv]
// Each amount passes through states RD2, RD3 and UPD in turn; a new request
// is taken only in the idle state, so one finishes before the next is accepted.
// The single table read port and one shared comparator force these steps in series.
// Reset: coin registers load 3 and 4; the table is not cleared, entry zero is written
// with every input transfer.
// ----------------------------------------------------------------------------
// Minimum coin change
// Fills a table of best coin counts from amount one up to the request.
// ----------------------------------------------------------------------------
`default_nettype none

module min_coin_change
    import mcc_pkg::*;
#(
    parameter int AMOUNT_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COIN_BITS-1:0]  amount,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [COUNT_BITS-1:0] min_coins,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_BITS-1:0]   cfg_data
);

    localparam int WIDE = (AMOUNT_BITS > COIN_BITS) ? AMOUNT_BITS : COIN_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD2  = 3'd1;
    localparam logic [2:0] ST_RD3  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [COIN_BITS-1:0]   second_coin_reg;
    logic [COIN_BITS-1:0]   third_coin_reg;
    logic [AMOUNT_BITS-1:0] target_reg;
    logic [AMOUNT_BITS-1:0] target_next;
    logic [AMOUNT_BITS-1:0] j_reg;
    logic [AMOUNT_BITS-1:0] j_next;
    logic [WIDE-1:0]        prev_reg;
    logic [WIDE-1:0]        prev_next;
    logic [WIDE-1:0]        cand_reg;
    logic [WIDE-1:0]        cand_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [COUNT_BITS-1:0]  min_coins_reg;
    logic [COUNT_BITS-1:0]  min_coins_next;

    logic [WIDE-1:0]        amount_ext;
    logic [WIDE-1:0]        j_ext;
    logic [WIDE-1:0]        diff2;
    logic [WIDE-1:0]        diff3;
    logic                   use2;
    logic                   use3;
    logic [AMOUNT_BITS-1:0] rd_addr;
    logic [WIDE-1:0]        rd_data;
    logic                   wr_en;
    logic [AMOUNT_BITS-1:0] wr_addr;
    logic [WIDE-1:0]        wr_data;
    logic [WIDE-1:0]        cmp_cur;
    logic                   cmp_use;
    logic [WIDE-1:0]        cmp_lowest;
    logic [WIDE-1:0]        count_new;

    assign amount_ext = WIDE'(amount);
    assign j_ext      = WIDE'(j_reg);
    assign diff2      = j_ext - WIDE'(second_coin_reg);
    assign diff3      = j_ext - WIDE'(third_coin_reg);
    assign use2       = (second_coin_reg != '0) && (WIDE'(second_coin_reg) <= j_ext);
    assign use3       = (third_coin_reg != '0) && (WIDE'(third_coin_reg) <= j_ext);
    assign rd_addr    = (state_reg == ST_RD3) ? diff3[AMOUNT_BITS-1:0]
                                              : diff2[AMOUNT_BITS-1:0];
    assign wr_en      = (state_reg == ST_UPD) || (in_valid && in_ready);
    assign wr_addr    = (state_reg == ST_UPD) ? j_reg : '0;
    assign wr_data    = (state_reg == ST_UPD) ? count_new : '0;
    assign cmp_cur    = (state_reg == ST_UPD) ? cand_reg : prev_reg;
    assign cmp_use    = (state_reg == ST_UPD) ? use3 : use2;
    assign count_new  = cmp_lowest + WIDE'(1);

    mcc_table #(
        .ADDR_BITS (AMOUNT_BITS),
        .DATA_BITS (WIDE)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mcc_min #(
        .WIDTH (WIDE)
    ) u_min (
        .cur      (cmp_cur),
        .cand     (rd_data),
        .use_cand (cmp_use),
        .lowest   (cmp_lowest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_coin_reg <= SECOND_COIN_RESET;
            third_coin_reg  <= THIRD_COIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SECOND_COIN: second_coin_reg <= cfg_data;
                CFG_THIRD_COIN:  third_coin_reg  <= cfg_data;
                default:         second_coin_reg <= second_coin_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        j_next         = j_reg;
        prev_next      = prev_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg;
        min_coins_next = min_coins_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    target_next = amount_ext[AMOUNT_BITS-1:0];
                    j_next      = AMOUNT_BITS'(1);
                    prev_next   = '0;
                    if (amount_ext[AMOUNT_BITS-1:0] == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD2;
                    end
                end
            end
            ST_RD2:
            begin
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                cand_next  = cmp_lowest;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                prev_next = count_new;
                if (j_reg == target_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    j_next     = j_reg + AMOUNT_BITS'(1);
                    state_next = ST_RD2;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    min_coins_next = prev_reg[COUNT_BITS-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        j_reg         <= j_next;
        prev_reg      <= prev_next;
        cand_reg      <= cand_next;
        min_coins_reg <= min_coins_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign min_coins = min_coins_reg;

endmodule

`default_nettype wire
